[src/sfr_pkg.sv]
// Shared constants and types for the setpoint frame receiver.
// Used by sfr_parser, sfr_out_reg and setpoint_frame_receiver_unit.
`timescale 1ns / 1ps
`default_nettype none
package sfr_pkg;

  localparam int unsigned FRAME_LEN   = 17;
  localparam int unsigned PAYLOAD_LEN = 14;
  localparam int unsigned POS_W       = 5;
  localparam int unsigned IDX_W       = 4;

  localparam logic [7:0] SYNC_FIRST  = 8'hAB;
  localparam logic [7:0] SYNC_SECOND = 8'hCD;

  // Frame status codes
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_BAD_SUM = 1'b1;

  typedef logic [POS_W-1:0] pos_t;

  // One decoded result word
  typedef struct packed {
    logic               status;
    logic signed [15:0] surge_setpoint;
    logic signed [15:0] sway_setpoint;
    logic signed [15:0] yaw_setpoint;
    logic signed [15:0] heave_setpoint;
    logic [7:0]         switch_one;
    logic [7:0]         switch_two;
    logic [7:0]         option_one;
    logic [7:0]         option_two;
    logic [7:0]         option_three;
    logic [7:0]         option_four;
  } sfr_result_t;

endpackage
`default_nettype wire

[src/sfr_parser.sv]
// Frame hunter: sync detect, byte position, running sum and payload store.
// Depends on sfr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sfr_parser (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                take,
  input  wire logic [7:0]          rx_byte,
  output logic                     at_check,
  output logic                     res_fire,
  output sfr_pkg::sfr_result_t     res
);
  import sfr_pkg::*;

  localparam pos_t LAST_POS  = pos_t'(FRAME_LEN - 1);
  localparam pos_t FRAME_POS = pos_t'(FRAME_LEN);

  pos_t       pos_r, pos_nxt, pos_eff, pos_m2;
  logic [7:0] sum_r, sum_nxt;
  logic [7:0] store_r [PAYLOAD_LEN];
  logic       store_we;

  // out-of-range position falls back to hunting
  assign pos_eff  = (pos_r >= FRAME_POS) ? '0 : pos_r;
  assign pos_m2   = pos_eff - pos_t'(2);
  assign at_check = (pos_eff == LAST_POS);
  assign store_we = take && (pos_eff >= pos_t'(2)) && (pos_eff < LAST_POS);

  // next state and result
  always_comb begin
    pos_nxt  = pos_r;
    sum_nxt  = sum_r;
    res_fire = 1'b0;
    res      = '0;
    if (take) begin
      if (pos_eff == pos_t'(0)) begin
        if (rx_byte == SYNC_FIRST) begin
          sum_nxt = rx_byte;
          pos_nxt = pos_t'(1);
        end else begin
          pos_nxt = '0;
        end
      end else if (pos_eff == pos_t'(1)) begin
        if (rx_byte == SYNC_SECOND) begin
          sum_nxt = sum_r + rx_byte;
          pos_nxt = pos_t'(2);
        end else begin
          pos_nxt = '0;
        end
      end else if (pos_eff < LAST_POS) begin
        sum_nxt = sum_r + rx_byte;
        pos_nxt = pos_eff + pos_t'(1);
      end else begin
        // checksum byte closes the frame
        pos_nxt  = '0;
        sum_nxt  = '0;
        res_fire = 1'b1;
        if (sum_r != rx_byte) begin
          res.status = STATUS_BAD_SUM;
        end else begin
          res.status         = STATUS_OK;
          res.surge_setpoint = $signed({store_r[0], store_r[1]});
          res.sway_setpoint  = $signed({store_r[2], store_r[3]});
          res.yaw_setpoint   = $signed({store_r[4], store_r[5]});
          res.heave_setpoint = $signed({store_r[6], store_r[7]});
          res.switch_one     = store_r[8];
          res.switch_two     = store_r[9];
          res.option_one     = store_r[10];
          res.option_two     = store_r[11];
          res.option_three   = store_r[12];
          res.option_four    = store_r[13];
        end
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      sum_r <= '0;
    end else begin
      pos_r <= pos_nxt;
      sum_r <= sum_nxt;
    end
  end

  // payload bytes, frame bytes 2..15
  always_ff @(posedge clk) begin
    if (store_we) begin
      store_r[pos_m2[IDX_W-1:0]] <= rx_byte;
    end
  end

endmodule
`default_nettype wire

[src/sfr_out_reg.sv]
// Result register holding one decoded word until the sink takes it.
// Depends on sfr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sfr_out_reg (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 load,
  input  wire sfr_pkg::sfr_result_t load_data,
  input  wire logic                 out_stall,
  output logic                      out_valid,
  output sfr_pkg::sfr_result_t      out_data
);
  import sfr_pkg::*;

  logic        valid_r;
  sfr_result_t data_r;

  // valid flag: set on load, cleared when the sink takes the word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (valid_r && !out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule
`default_nettype wire

[src/setpoint_frame_receiver_unit.sv]
// Top level of the setpoint frame receiver.
// Depends on sfr_pkg, sfr_parser and sfr_out_reg.
`timescale 1ns / 1ps
`default_nettype none
// Takes one received byte per cycle and hunts for 17-byte frames opened by
// 0xAB 0xCD and closed by an 8-bit sum of the first 16 bytes. Each byte is
// handled by the position/sum logic; the checksum byte produces one result
// word in the output register on the next edge (status 0 with the four
// big-endian setpoints and six raw bytes, or status 1 with all
// other fields zero). Input is stalled only when a checksum byte arrives
// while the previous result is still held and stalled; otherwise a byte is
// accepted every cycle.
module setpoint_frame_receiver_unit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [7:0]         in_rx_byte,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    out_status,
  output logic signed [15:0]      out_surge_setpoint,
  output logic signed [15:0]      out_sway_setpoint,
  output logic signed [15:0]      out_yaw_setpoint,
  output logic signed [15:0]      out_heave_setpoint,
  output logic [7:0]              out_switch_one,
  output logic [7:0]              out_switch_two,
  output logic [7:0]              out_option_one,
  output logic [7:0]              out_option_two,
  output logic [7:0]              out_option_three,
  output logic [7:0]              out_option_four
);
  import sfr_pkg::*;

  logic        take;
  logic        at_check;
  logic        res_fire;
  sfr_result_t res;
  sfr_result_t out_data;

  // hold back only a checksum byte that has nowhere to go
  assign in_stall = at_check && out_valid && out_stall;
  assign take     = in_valid && !in_stall;

  sfr_parser u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .take     (take),
    .rx_byte  (in_rx_byte),
    .at_check (at_check),
    .res_fire (res_fire),
    .res      (res)
  );

  sfr_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (res_fire),
    .load_data (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  assign out_status         = out_data.status;
  assign out_surge_setpoint = out_data.surge_setpoint;
  assign out_sway_setpoint  = out_data.sway_setpoint;
  assign out_yaw_setpoint   = out_data.yaw_setpoint;
  assign out_heave_setpoint = out_data.heave_setpoint;
  assign out_switch_one     = out_data.switch_one;
  assign out_switch_two     = out_data.switch_two;
  assign out_option_one     = out_data.option_one;
  assign out_option_two     = out_data.option_two;
  assign out_option_three   = out_data.option_three;
  assign out_option_four    = out_data.option_four;

endmodule
`default_nettype wire

[tb/sv/tb_setpoint_frame_receiver_unit.sv]
// Testbench for setpoint_frame_receiver_unit: sync hunt, frame decode and checksum checks.
// Depends on sfr_pkg and setpoint_frame_receiver_unit; self-checking, no files read.
`timescale 1ns / 1ps
module tb_setpoint_frame_receiver_unit;
  import sfr_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES   = 20;
  localparam int unsigned LONG_HOLD      = 300;

  // Payload bytes of one frame, byte 2 of the frame first
  typedef logic [0:PAYLOAD_LEN-1][7:0] frame_body_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic [7:0] in_rx_byte = 8'h00;
  logic out_stall = 1'b0;
  logic in_stall;
  logic out_valid;
  logic out_status;
  logic signed [15:0] out_surge_setpoint;
  logic signed [15:0] out_sway_setpoint;
  logic signed [15:0] out_yaw_setpoint;
  logic signed [15:0] out_heave_setpoint;
  logic [7:0] out_switch_one;
  logic [7:0] out_switch_two;
  logic [7:0] out_option_one;
  logic [7:0] out_option_two;
  logic [7:0] out_option_three;
  logic [7:0] out_option_four;

  // Decoder mirror: position, running sum, stored payload
  pos_t hunt_pos = '0;
  logic [7:0] hunt_sum = 8'h00;
  logic [7:0] frame_bytes [PAYLOAD_LEN];
  sfr_result_t expected_frames [$];

  bit idle_en = 1'b0;
  int unsigned rx_hold_len = 0;
  int unsigned bytes_sent = 0;
  int unsigned words_checked = 0;
  int unsigned mismatch_count = 0;

  setpoint_frame_receiver_unit dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_surge_setpoint (out_surge_setpoint),
    .out_sway_setpoint  (out_sway_setpoint),
    .out_yaw_setpoint   (out_yaw_setpoint),
    .out_heave_setpoint (out_heave_setpoint),
    .out_switch_one     (out_switch_one),
    .out_switch_two     (out_switch_two),
    .out_option_one     (out_option_one),
    .out_option_two     (out_option_two),
    .out_option_three   (out_option_three),
    .out_option_four    (out_option_four)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("[%0t] MISMATCH: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("word %0d %s: got %h, expected %h",
                                words_checked, name, got, want));
  endtask

  // Advance the decoder mirror by one accepted byte; queue a word on the checksum byte
  function automatic void track_frame_byte(input logic [7:0] b);
    sfr_result_t word;
    pos_t p;
    p = (hunt_pos >= FRAME_LEN) ? pos_t'(0) : hunt_pos;
    if (p == 0) begin
      if (b == SYNC_FIRST) begin
        hunt_sum = b;
        hunt_pos = pos_t'(1);
      end else begin
        hunt_pos = '0;
      end
    end else if (p == 1) begin
      // a wrong second sync byte is dropped, not retried as a first one
      if (b == SYNC_SECOND) begin
        hunt_sum = hunt_sum + b;
        hunt_pos = pos_t'(2);
      end else begin
        hunt_pos = '0;
      end
    end else if (p < FRAME_LEN - 1) begin
      frame_bytes[p - 2] = b;
      hunt_sum = hunt_sum + b;
      hunt_pos = p + 1'b1;
    end else begin
      word = '0;
      if (hunt_sum != b) begin
        word.status = STATUS_BAD_SUM;
      end else begin
        word.status         = STATUS_OK;
        word.surge_setpoint = {frame_bytes[0], frame_bytes[1]};
        word.sway_setpoint  = {frame_bytes[2], frame_bytes[3]};
        word.yaw_setpoint   = {frame_bytes[4], frame_bytes[5]};
        word.heave_setpoint = {frame_bytes[6], frame_bytes[7]};
        word.switch_one     = frame_bytes[8];
        word.switch_two     = frame_bytes[9];
        word.option_one     = frame_bytes[10];
        word.option_two     = frame_bytes[11];
        word.option_three   = frame_bytes[12];
        word.option_four    = frame_bytes[13];
      end
      hunt_sum = 8'h00;
      hunt_pos = '0;
      expected_frames.push_back(word);
    end
  endfunction

  // Check each accepted result word, then track each accepted byte
  always @(posedge clk) begin : result_checker
    sfr_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_frames.size() == 0) begin
        report_mismatch("result word with none expected");
      end else begin
        want = expected_frames.pop_front();
        check_field("status", 16'(out_status), 16'(want.status));
        check_field("surge", out_surge_setpoint, want.surge_setpoint);
        check_field("sway", out_sway_setpoint, want.sway_setpoint);
        check_field("yaw", out_yaw_setpoint, want.yaw_setpoint);
        check_field("heave", out_heave_setpoint, want.heave_setpoint);
        check_field("switch_one", 16'(out_switch_one), 16'(want.switch_one));
        check_field("switch_two", 16'(out_switch_two), 16'(want.switch_two));
        check_field("option_one", 16'(out_option_one), 16'(want.option_one));
        check_field("option_two", 16'(out_option_two), 16'(want.option_two));
        check_field("option_three", 16'(out_option_three), 16'(want.option_three));
        check_field("option_four", 16'(out_option_four), 16'(want.option_four));
      end
      words_checked++;
    end
    if (rst_n && in_valid && !in_stall)
      track_frame_byte(in_rx_byte);
  end

  // Receiver: random stall bursts, or one long hold when asked
  initial begin : result_sink
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (rx_hold_len > 0) begin
        out_stall <= 1'b1;
        repeat (rx_hold_len) @(posedge clk);
        rx_hold_len = 0;
        out_stall <= 1'b0;
      end else if (idle_en && $urandom_range(0, 9) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Ends the run if neither channel moves a word for too long
  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    @(posedge rst_n);
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("Timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  // Offer one byte, with an optional random gap first, and wait until it is taken
  task automatic send_byte(input logic [7:0] b);
    if (idle_en && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  // Full frame; a nonzero sum_flip corrupts the checksum byte
  task automatic send_frame(input frame_body_t body, input logic [7:0] sum_flip);
    logic [7:0] sum;
    sum = SYNC_FIRST + SYNC_SECOND;
    send_byte(SYNC_FIRST);
    send_byte(SYNC_SECOND);
    for (int k = 0; k < PAYLOAD_LEN; k++) begin
      send_byte(body[k]);
      sum = sum + body[k];
    end
    send_byte(sum ^ sum_flip);
  endtask

  function automatic frame_body_t random_body();
    frame_body_t body;
    for (int k = 0; k < PAYLOAD_LEN; k++)
      body[k] = 8'($urandom_range(0, 255));
    return body;
  endfunction

  // Noise at position 0 and wrong second sync bytes, the last one being 0xAB
  task automatic test_sync_hunt();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(SYNC_SECOND);
    send_byte(SYNC_FIRST);
    send_byte(8'h00);
    send_byte(SYNC_FIRST);
    send_byte(SYNC_FIRST);
    send_byte(SYNC_SECOND);
  endtask

  // Setpoint extremes and raw byte extremes, then the same frame with a bad sum
  task automatic test_field_extremes();
    frame_body_t body;
    body = {8'h80, 8'h00, 8'h7F, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00,
            8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'h80};
    send_frame(body, 8'h00);
    send_frame(body, 8'h01);
  endtask

  // Mostly good frames; some bad sums, noise, broken and cut-short frames
  task automatic test_random_traffic(input int unsigned n_bytes);
    int unsigned stop_at;
    int unsigned pick;
    logic [7:0] b;
    stop_at = bytes_sent + n_bytes;
    idle_en = 1'b1;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        send_frame(random_body(), 8'h00);
      end else if (pick < 82) begin
        send_frame(random_body(), 8'($urandom_range(1, 255)));
      end else if (pick < 90) begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
      end else if (pick < 95) begin
        send_byte(SYNC_FIRST);
        b = 8'($urandom_range(0, 255));
        if (b == SYNC_SECOND) b = ~b;
        send_byte(b);
      end else begin
        // sync then a short run; the next frame's bytes land in its payload
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        repeat ($urandom_range(0, 13)) send_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  // Receiver holds off while frames keep coming, so the block stalls its input
  task automatic test_output_backpressure();
    idle_en = 1'b0;
    rx_hold_len = LONG_HOLD;
    repeat (4) send_frame(random_body(), 8'h00);
  endtask

  // Back-to-back frames with no idling on either side
  task automatic test_back_to_back(input int unsigned n_bytes);
    int unsigned stop_at;
    stop_at = bytes_sent + n_bytes;
    idle_en = 1'b0;
    while (bytes_sent < stop_at) begin
      if ($urandom_range(0, 5) == 0)
        send_frame(random_body(), 8'($urandom_range(1, 255)));
      else
        send_frame(random_body(), 8'h00);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_sync_hunt();
    test_field_extremes();
    test_random_traffic(420);
    test_output_backpressure();
    test_back_to_back(170);

    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

[filelist.f]
src/sfr_pkg.sv
src/sfr_parser.sv
src/sfr_out_reg.sv
src/setpoint_frame_receiver_unit.sv
tb/sv/tb_setpoint_frame_receiver_unit.sv
